@@ rtl/core/dr_vb_pkg.sv @@
// Shared types and helpers for the dead reckoning velocity blend block.
// No dependencies.
package dr_vb_pkg;

  localparam logic [1:0] KIND_PACKET  = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_RUN     = 2'd2;
  localparam logic [1:0] KIND_SNAP    = 2'd3;

  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
    logic               shift_hi;  // round off one more bit
    logic               usat;      // saturate to the unsigned range
  } mul_req_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

endpackage

@@ rtl/core/dr_vb_mul.sv @@
// Shared multiplier: product, round to nearest, saturate, registered.
// Depends on dr_vb_pkg.
module dr_vb_mul import dr_vb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  mul_req_t    req_i,
  output logic [31:0] res_o
);

  logic signed [65:0] prod;
  logic signed [65:0] rnd;
  logic signed [65:0] shf;
  logic [5:0]         sh;
  logic [31:0]        res_d;

  assign sh   = 6'(FRAC_BITS) + 6'(req_i.shift_hi);
  assign prod = req_i.a * req_i.b;
  assign rnd  = prod + (66'sd1 <<< (sh - 6'd1));
  assign shf  = rnd >>> sh;

  always_comb begin
    if (req_i.usat) begin
      res_d = (shf > 66'sh0ffffffff) ? 32'hffffffff : shf[31:0];
    end else if (shf > 66'sd2147483647) begin
      res_d = 32'h7fffffff;
    end else if (shf < -66'sd2147483648) begin
      res_d = 32'h80000000;
    end else begin
      res_d = shf[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

endmodule

@@ rtl/core/dr_vb_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependency.
module dr_vb_div #(
  parameter int NW = 49
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] numer_i,
  input  logic [31:0]   denom_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] num_q;
  logic [31:0]   rem_q;
  logic [31:0]   den_q;
  logic [32:0]   trial;
  logic          fits;

  assign trial = {rem_q, num_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= numer_i;
      rem_q <= '0;
      den_q <= denom_i;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], fits};
      rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

@@ rtl/core/dead_reckoning_velocity_blend.sv @@
// Two-axis dead reckoning with projective velocity blending, Q-format fixed point.
// Packet and advance transfers give no result. A snap gives its result through the
// output state, where it waits while an earlier result is still held. A run before
// the second packet projects each axis with the shared multiplier; a run after it
// also computes the blend fraction and the two instant velocity divisions, with
// one shared multiplier and a one-bit-per-cycle divider.
// Depends on dr_vb_pkg, dr_vb_mul, dr_vb_div.
module dead_reckoning_velocity_blend import dr_vb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_blend_period_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic signed [31:0] pkt_pos_x_i,
  input  logic signed [31:0] pkt_pos_y_i,
  input  logic signed [31:0] pkt_vel_x_i,
  input  logic signed [31:0] pkt_vel_y_i,
  input  logic signed [31:0] pkt_acc_x_i,
  input  logic signed [31:0] pkt_acc_y_i,
  input  logic signed [31:0] pkt_heading_i,
  input  logic [31:0] step_time_i,
  input  logic signed [31:0] shown_pos_x_i,
  input  logic signed [31:0] shown_pos_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic signed [31:0] out_heading_o
);

  localparam int NW = 33 + FRAC_BITS;
  localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_FRAC  = 5'd1;
  localparam logic [4:0] ST_FWAIT = 5'd2;
  localparam logic [4:0] ST_TSQ   = 5'd3;
  localparam logic [4:0] ST_TSQW  = 5'd4;
  localparam logic [4:0] ST_KAT   = 5'd5;
  localparam logic [4:0] ST_KVT   = 5'd6;
  localparam logic [4:0] ST_KSUM  = 5'd7;
  localparam logic [4:0] ST_VB    = 5'd8;
  localparam logic [4:0] ST_VB2   = 5'd9;
  localparam logic [4:0] ST_AT    = 5'd10;
  localparam logic [4:0] ST_VT    = 5'd11;
  localparam logic [4:0] ST_VT2   = 5'd12;
  localparam logic [4:0] ST_FIN   = 5'd13;
  localparam logic [4:0] ST_FIN2  = 5'd14;
  localparam logic [4:0] ST_DWAIT = 5'd15;
  localparam logic [4:0] ST_OUT   = 5'd16;

  logic [4:0] state_q, state_d;

  logic [31:0] bp_q;
  logic signed [31:0] kpos_q [2];
  logic signed [31:0] kvel_q [2];
  logic signed [31:0] kacc_q [2];
  logic signed [31:0] ppos_q [2];
  logic signed [31:0] pvel_q [2];
  logic signed [31:0] cpos_q [2];
  logic signed [31:0] ivel_q [2];
  logic signed [31:0] heading_q;
  logic [31:0] et_q;
  logic        seen_q;
  logic        extrap_q;

  logic [31:0] dt_q;
  logic signed [31:0] shown_q [2];
  logic [31:0] tsq_q;
  logic signed [32:0] frac_q;
  logic        ax_q;
  logic signed [31:0] vb_q, at_q, pt_q, ptp_q;
  logic signed [31:0] pos_q [2];
  logic signed [31:0] vel_q [2];
  logic        dneg_q;

  logic        out_valid_q;
  logic signed [31:0] opx_q, opy_q, ovx_q, ovy_q, ohd_q;

  mul_req_t    mreq;
  logic [31:0] mres;
  logic signed [31:0] mres_s;
  logic        dstart;
  logic [NW-1:0] dnum;
  logic [31:0] dden;
  logic        ddone;
  logic [NW-1:0] dquot;

  logic        in_xfer;
  logic [31:0] tsel;
  logic signed [31:0] fin_w;
  logic signed [32:0] dpos;
  logic [32:0] dmag;
  logic signed [31:0] iv_w;
  logic [32:0] e_sum;

  assign mres_s   = $signed(mres);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign tsel     = extrap_q ? et_q : dt_q;
  assign fin_w    = sat34(sx34(pt_q) + sx34(mres_s));
  assign dpos     = 33'(fin_w) - 33'(shown_q[ax_q]);
  assign dmag     = dpos[32] ? 33'(-dpos) : 33'(dpos);
  assign e_sum    = {1'b0, et_q} + {1'b0, step_time_i};

  always_comb begin
    if (dneg_q) begin
      iv_w = (dquot > NW'(33'h080000000)) ? 32'sh80000000 : $signed(~dquot[31:0] + 32'd1);
    end else begin
      iv_w = (dquot > NW'(33'h07fffffff)) ? 32'sh7fffffff : $signed(dquot[31:0]);
    end
  end

  always_comb begin
    mreq = '0;
    case (state_q)
      ST_TSQ: begin
        mreq.a    = {1'b0, tsel};
        mreq.b    = {1'b0, tsel};
        mreq.usat = 1'b1;
      end
      ST_KAT, ST_VB2: begin
        mreq.a        = 33'(kacc_q[ax_q]);
        mreq.b        = {1'b0, tsq_q};
        mreq.shift_hi = 1'b1;
      end
      ST_KVT: begin
        mreq.a = 33'(kvel_q[ax_q]);
        mreq.b = {1'b0, dt_q};
      end
      ST_VT: begin
        mreq.a = 33'(kvel_q[ax_q]);
        mreq.b = {1'b0, et_q};
      end
      ST_VB: begin
        mreq.a = 33'(kvel_q[ax_q]) - 33'(pvel_q[ax_q]);
        mreq.b = frac_q;
      end
      ST_AT: begin
        mreq.a = 33'(vb_q);
        mreq.b = {1'b0, et_q};
      end
      ST_FIN: begin
        mreq.a = 33'(ptp_q) - 33'(pt_q);
        mreq.b = frac_q;
      end
      default: mreq = '0;
    endcase
  end

  always_comb begin
    dstart = 1'b0;
    dnum   = NW'(dmag) << FRAC_BITS;
    dden   = dt_q;
    if (state_q == ST_FRAC) begin
      dstart = (bp_q != 32'd0);
      dnum   = NW'(et_q) << FRAC_BITS;
      dden   = bp_q;
    end else if (state_q == ST_FIN2) begin
      dstart = (dt_q != 32'd0);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && kind_i == KIND_SNAP) begin
          state_d = ST_OUT;
        end else if (in_xfer && kind_i == KIND_RUN) begin
          state_d = extrap_q ? ST_FRAC : ST_TSQ;
        end
      end
      ST_FRAC:  state_d = (bp_q != 32'd0) ? ST_FWAIT : ST_TSQ;
      ST_FWAIT: state_d = ddone ? ST_TSQ : ST_FWAIT;
      ST_TSQ:   state_d = ST_TSQW;
      ST_TSQW:  state_d = extrap_q ? ST_VB : ST_KAT;
      ST_KAT:   state_d = ST_KVT;
      ST_KVT:   state_d = ST_KSUM;
      ST_KSUM:  state_d = ax_q ? ST_OUT : ST_KAT;
      ST_VB:    state_d = ST_VB2;
      ST_VB2:   state_d = ST_AT;
      ST_AT:    state_d = ST_VT;
      ST_VT:    state_d = ST_VT2;
      ST_VT2:   state_d = ST_FIN;
      ST_FIN:   state_d = ST_FIN2;
      ST_FIN2: begin
        if (dt_q != 32'd0) begin
          state_d = ST_DWAIT;
        end else begin
          state_d = ax_q ? ST_OUT : ST_VB;
        end
      end
      ST_DWAIT: begin
        if (ddone) begin
          state_d = ax_q ? ST_OUT : ST_VB;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bp_q        <= 32'd1 << FRAC_BITS;
      heading_q   <= '0;
      et_q        <= '0;
      seen_q      <= 1'b0;
      extrap_q    <= 1'b0;
      out_valid_q <= 1'b0;
      ax_q        <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        kpos_q[i] <= '0;
        kvel_q[i] <= '0;
        kacc_q[i] <= '0;
        ppos_q[i] <= '0;
        pvel_q[i] <= '0;
        cpos_q[i] <= '0;
        ivel_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        bp_q <= cfg_blend_period_i;
      end
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_xfer) begin
        ax_q <= 1'b0;
        case (kind_i)
          KIND_PACKET: begin
            for (int i = 0; i < 2; i++) begin
              ppos_q[i] <= cpos_q[i];
              pvel_q[i] <= ivel_q[i];
            end
            kpos_q[0] <= pkt_pos_x_i;
            kpos_q[1] <= pkt_pos_y_i;
            kvel_q[0] <= pkt_vel_x_i;
            kvel_q[1] <= pkt_vel_y_i;
            kacc_q[0] <= pkt_acc_x_i;
            kacc_q[1] <= pkt_acc_y_i;
            heading_q <= pkt_heading_i;
            et_q      <= '0;
            seen_q    <= 1'b1;
            if (seen_q) begin
              extrap_q <= 1'b1;
            end
          end
          KIND_ADVANCE: begin
            et_q <= e_sum[32] ? 32'hffffffff : e_sum[31:0];
          end
          KIND_SNAP: begin
            for (int i = 0; i < 2; i++) begin
              ppos_q[i] <= kpos_q[i];
              pvel_q[i] <= kvel_q[i];
            end
          end
          default: ;
        endcase
      end
      case (state_q)
        ST_KSUM: begin
          cpos_q[ax_q] <= sat34(sx34(kpos_q[ax_q]) + sx34(mres_s) + sx34(at_q));
          ax_q <= 1'b1;
        end
        ST_FIN2: begin
          cpos_q[ax_q] <= fin_w;
          if (dt_q == 32'd0) begin
            ax_q <= 1'b1;
          end
        end
        ST_DWAIT: begin
          if (ddone) begin
            ivel_q[ax_q] <= iv_w;
            ax_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dt_q       <= step_time_i;
      shown_q[0] <= shown_pos_x_i;
      shown_q[1] <= shown_pos_y_i;
      if (kind_i == KIND_SNAP) begin
        for (int i = 0; i < 2; i++) begin
          pos_q[i] <= kpos_q[i];
          vel_q[i] <= kvel_q[i];
        end
      end
    end
    case (state_q)
      ST_FRAC: begin
        if (bp_q == 32'd0) begin
          frac_q <= ONE;
        end
      end
      ST_FWAIT: begin
        if (ddone) begin
          frac_q <= (dquot > NW'(ONE)) ? ONE : $signed(dquot[32:0]);
        end
      end
      ST_TSQW: tsq_q <= mres;
      ST_KVT:  at_q  <= mres_s;
      ST_KSUM: begin
        pos_q[ax_q] <= sat34(sx34(kpos_q[ax_q]) + sx34(mres_s) + sx34(at_q));
        vel_q[ax_q] <= pvel_q[ax_q];
      end
      ST_VB2: begin
        vb_q        <= sat34(sx34(pvel_q[ax_q]) + sx34(mres_s));
        vel_q[ax_q] <= sat34(sx34(pvel_q[ax_q]) + sx34(mres_s));
      end
      ST_AT:   at_q  <= mres_s;
      ST_VT:   pt_q  <= sat34(sx34(ppos_q[ax_q]) + sx34(mres_s) + sx34(at_q));
      ST_VT2:  ptp_q <= sat34(sx34(kpos_q[ax_q]) + sx34(mres_s) + sx34(at_q));
      ST_FIN2: begin
        pos_q[ax_q] <= fin_w;
        dneg_q      <= dpos[32];
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          opx_q <= pos_q[0];
          opy_q <= pos_q[1];
          ovx_q <= vel_q[0];
          ovy_q <= vel_q[1];
          ohd_q <= heading_q;
        end
      end
      default: ;
    endcase
  end

  dr_vb_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .req_i (mreq),
    .res_o (mres)
  );

  dr_vb_div #(
    .NW(NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart),
    .numer_i (dnum),
    .denom_i (dden),
    .done_o  (ddone),
    .quot_o  (dquot)
  );

  assign out_valid_o   = out_valid_q;
  assign out_pos_x_o   = opx_q;
  assign out_pos_y_o   = opy_q;
  assign out_vel_x_o   = ovx_q;
  assign out_vel_y_o   = ovy_q;
  assign out_heading_o = ohd_q;

endmodule

@@ rtl/core/dr_vb_checker.sv @@
// Port-level checks for dead_reckoning_velocity_blend, bound to the top level.
// Depends on dr_vb_pkg.
module dr_vb_props import dr_vb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_ready_o,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  kind_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] out_pos_x_o
);

  // a run transfer occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_RUN |=> !in_ready_o)
    else $error("ready after run transfer");

  // packet and advance complete in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_PACKET || kind_i == KIND_ADVANCE)
    |=> in_ready_o)
    else $error("busy after packet or advance");

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o && cfg_ready_o == cfg_ready_o)
    else $error("result valid in reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_pos_x_o))
    else $error("stalled result changed");

endmodule

bind dead_reckoning_velocity_blend dr_vb_props u_dr_vb_props (.*);

@@ tb/sv/dr_vb_checker.sv @@
// Checker for the dead reckoning velocity blend block: watches the config, input
// and result channels, predicts each result and compares it field by field.
// Depends on dr_vb_pkg.
`timescale 1ns / 1ps
module dr_vb_checker import dr_vb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_blend_period_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic signed [31:0] pkt_pos_x_i,
  input  logic signed [31:0] pkt_pos_y_i,
  input  logic signed [31:0] pkt_vel_x_i,
  input  logic signed [31:0] pkt_vel_y_i,
  input  logic signed [31:0] pkt_acc_x_i,
  input  logic signed [31:0] pkt_acc_y_i,
  input  logic signed [31:0] pkt_heading_i,
  input  logic [31:0] step_time_i,
  input  logic signed [31:0] shown_pos_x_i,
  input  logic signed [31:0] shown_pos_y_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic signed [31:0] out_pos_x_i,
  input  logic signed [31:0] out_pos_y_i,
  input  logic signed [31:0] out_vel_x_i,
  input  logic signed [31:0] out_vel_y_i,
  input  logic signed [31:0] out_heading_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);
  localparam int FB = 16;

  typedef struct {
    logic signed [31:0] px, py, vx, vy, hd;
  } motion_t;

  motion_t future_q[$];

  logic [31:0] period;
  logic signed [31:0] kpos[2], kvel[2], kacc[2], ppos[2], pvel[2], cpos[2], ivel[2];
  logic signed [31:0] hdg;
  logic [31:0] elapsed;
  logic got_first, blending;

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_rnd(input longint a, input longint b, input int s);
    return (a * b + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint tsq(input logic [31:0] t);
    logic [63:0] p;
    p = ({32'd0, t} * {32'd0, t} + (64'd1 << (FB - 1))) >> FB;
    return (p > 64'hffffffff) ? 64'sh ffffffff : longint'(p);
  endfunction

  function automatic longint project(input longint p, input longint v, input longint a,
                                     input logic [31:0] t);
    longint vt, at;
    vt = sat(mul_rnd(v, longint'({32'd0, t}), FB));
    at = sat(mul_rnd(a, tsq(t), FB + 1));
    return sat(p + vt + at);
  endfunction

  function automatic longint mix(input longint a, input longint b, input longint f);
    return sat(a + sat(mul_rnd(b - a, f, FB)));
  endfunction

  task automatic advance_model();
    motion_t m;
    longint frac, vb, pt, ptp, fin, d;
    logic [63:0] s;
    logic signed [31:0] shown[2];
    shown[0] = shown_pos_x_i;
    shown[1] = shown_pos_y_i;
    case (kind_i)
      KIND_PACKET: begin
        ppos = cpos;
        pvel = ivel;
        kpos[0] = pkt_pos_x_i; kpos[1] = pkt_pos_y_i;
        kvel[0] = pkt_vel_x_i; kvel[1] = pkt_vel_y_i;
        kacc[0] = pkt_acc_x_i; kacc[1] = pkt_acc_y_i;
        hdg = pkt_heading_i;
        elapsed = '0;
        if (got_first) blending = 1'b1;
        got_first = 1'b1;
      end
      KIND_ADVANCE: begin
        s = {32'd0, elapsed} + {32'd0, step_time_i};
        elapsed = (s > 64'hffffffff) ? 32'hffffffff : s[31:0];
      end
      KIND_SNAP: begin
        ppos = kpos;
        pvel = kvel;
        m.px = kpos[0]; m.py = kpos[1]; m.vx = kvel[0]; m.vy = kvel[1]; m.hd = hdg;
        future_q.push_back(m);
      end
      default: begin
        if (!blending) begin
          for (int i = 0; i < 2; i++)
            cpos[i] = 32'(project(kpos[i], kvel[i], kacc[i], step_time_i));
          m.px = cpos[0]; m.py = cpos[1]; m.vx = pvel[0]; m.vy = pvel[1];
        end else begin
          frac = 64'sd1 << FB;
          if (period != 0) begin
            frac = longint'(({32'd0, elapsed} << FB) / {32'd0, period});
            if (frac > (64'sd1 << FB)) frac = 64'sd1 << FB;
          end
          for (int i = 0; i < 2; i++) begin
            vb = mix(pvel[i], kvel[i], frac);
            pt = project(ppos[i], vb, kacc[i], elapsed);
            ptp = project(kpos[i], kvel[i], kacc[i], elapsed);
            fin = mix(pt, ptp, frac);
            if (step_time_i != 0) begin
              d = fin - longint'(shown[i]);
              ivel[i] = 32'(sat((d * (64'sd1 << FB)) / longint'({32'd0, step_time_i})));
            end
            cpos[i] = 32'(fin);
            if (i == 0) begin m.px = 32'(fin); m.vx = 32'(vb); end
            else begin m.py = 32'(fin); m.vy = 32'(vb); end
          end
        end
        m.hd = hdg;
        future_q.push_back(m);
      end
    endcase
  endtask

  task automatic report(input string f, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      if (fail_count_o < 10)
        $display("mismatch %s at result %0d: expected %h got %h", f, result_count_o, e, a);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    motion_t m;
    if (!rst_ni) begin
      period = 32'h0001_0000;
      for (int i = 0; i < 2; i++) begin
        kpos[i] = 0; kvel[i] = 0; kacc[i] = 0; ppos[i] = 0;
        pvel[i] = 0; cpos[i] = 0; ivel[i] = 0;
      end
      hdg = 0; elapsed = 0; got_first = 0; blending = 0;
      future_q.delete();
      fail_count_o = 0;
      result_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) period = cfg_blend_period_i;
      if (out_valid_i && out_ready_i) begin
        if (future_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result transfer");
          fail_count_o++;
        end else begin
          m = future_q.pop_front();
          report("pos_x", m.px, out_pos_x_i);
          report("pos_y", m.py, out_pos_y_i);
          report("vel_x", m.vx, out_vel_x_i);
          report("vel_y", m.vy, out_vel_y_i);
          report("heading", m.hd, out_heading_i);
        end
        result_count_o++;
      end
      if (in_valid_i && in_ready_i) advance_model();
      pending_o = future_q.size();
    end
  end
endmodule

@@ tb/sv/dead_reckoning_velocity_blend_test.sv @@
// Top of the dead reckoning velocity blend testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on dr_vb_pkg, the block and dr_vb_checker.
`timescale 1ns / 1ps
module dead_reckoning_velocity_blend_test;
  import dr_vb_pkg::*;

  localparam int NUM_RANDOM = 1630;
  localparam longint CYCLE_LIMIT = 1_500_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_blend_period_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] kind_i = KIND_PACKET;
  logic signed [31:0] pkt_pos_x_i = 0, pkt_pos_y_i = 0, pkt_vel_x_i = 0, pkt_vel_y_i = 0;
  logic signed [31:0] pkt_acc_x_i = 0, pkt_acc_y_i = 0, pkt_heading_i = 0;
  logic [31:0] step_time_i = '0;
  logic signed [31:0] shown_pos_x_i = 0, shown_pos_y_i = 0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_vel_x_o, out_vel_y_o, out_heading_o;

  int fail_count, pending, result_count;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int sent = 0;

  always #1 clk_i = ~clk_i;

  dead_reckoning_velocity_blend DUT (.*);

  dr_vb_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_blend_period_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i,
    .pkt_pos_x_i, .pkt_pos_y_i, .pkt_vel_x_i, .pkt_vel_y_i,
    .pkt_acc_x_i, .pkt_acc_y_i, .pkt_heading_i, .step_time_i,
    .shown_pos_x_i, .shown_pos_y_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .out_pos_x_i(out_pos_x_o), .out_pos_y_i(out_pos_y_o),
    .out_vel_x_i(out_vel_x_o), .out_vel_y_i(out_vel_y_o), .out_heading_i(out_heading_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stall pattern, plus a long hold-off on request
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) out_ready_i <= 1'b0;
      else begin
        mode = (sent / 200) % 3;
        if (mode == 0) out_ready_i <= 1'b1;
        else if (mode == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
        else out_ready_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  function automatic logic [31:0] edge_val();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] mild_val();
    logic [31:0] v;
    v = $urandom_range(0, 32'h00ff_ffff);
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  task automatic send(input logic [1:0] k, input bit wide);
    @(negedge clk_i);
    kind_i <= k;
    pkt_pos_x_i <= wide ? edge_val() : mild_val();
    pkt_pos_y_i <= wide ? edge_val() : mild_val();
    pkt_vel_x_i <= wide ? edge_val() : mild_val();
    pkt_vel_y_i <= wide ? edge_val() : mild_val();
    pkt_acc_x_i <= wide ? edge_val() : mild_val();
    pkt_acc_y_i <= wide ? edge_val() : mild_val();
    pkt_heading_i <= $urandom();
    step_time_i <= wide ? edge_val() : $urandom_range(0, 32'h0002_0000);
    shown_pos_x_i <= wide ? edge_val() : mild_val();
    shown_pos_y_i <= wide ? edge_val() : mild_val();
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_period(input logic [31:0] p);
    drain();
    @(negedge clk_i);
    cfg_blend_period_i <= p;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] periods[6];
    logic [1:0] k;
    int burst;
    periods = '{32'h0001_0000, 32'h1, 32'hffffffff, 32'h0000_8000, 32'h0004_0000, 32'h0};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: run and snap before any packet, then extremes through all kinds
    send(KIND_RUN, 1'b0);
    send(KIND_SNAP, 1'b0);
    send(KIND_PACKET, 1'b1);
    send(KIND_RUN, 1'b1);
    send(KIND_ADVANCE, 1'b1);
    send(KIND_PACKET, 1'b1);
    send(KIND_RUN, 1'b1);
    send(KIND_ADVANCE, 1'b1);
    send(KIND_ADVANCE, 1'b1);
    send(KIND_RUN, 1'b1);
    send(KIND_SNAP, 1'b1);
    send(KIND_RUN, 1'b0);
    set_period(32'h1);
    send(KIND_PACKET, 1'b0);
    send(KIND_ADVANCE, 1'b0);
    send(KIND_RUN, 1'b0);
    set_period(32'h0);
    send(KIND_RUN, 1'b0);
    send(KIND_RUN, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      set_period(periods[ph]);
      if (ph == 2) begin
        // receiver holds off long while the sender keeps offering runs
        fork
          begin
            hold_off = 1'b1;
            repeat (800) @(posedge clk_i);
            hold_off = 1'b0;
          end
          repeat (20) send(KIND_RUN, 1'b0);
        join
      end
      while (sent < 20 + (ph + 1) * NUM_RANDOM / 6) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          // mostly well-formed frames: packet, advances, runs; some noise
          case ($urandom_range(0, 9))
            0, 1: k = KIND_PACKET;
            2, 3: k = KIND_ADVANCE;
            4: k = KIND_SNAP;
            default: k = KIND_RUN;
          endcase
          send(k, $urandom_range(0, 9) == 0);
        end
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 60)) @(posedge clk_i);
      end
    end
    drain();
    $display("run covered %0d input transfers and %0d results over six blend periods",
             sent, result_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
